@@ hw/rtl/rht_pkg.sv @@
// Shared types for the reference-counted handle tracker.
// Holds operation codes, sequencer states and the result record.
// No dependencies.
`timescale 1ns / 1ps

package rht_pkg;

  localparam int MODE_BITS    = 3;
  localparam int IN_USE_BITS  = 6;
  localparam int OUT_TDATA_W  = 8;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_REGISTER   = 3'd0,
    MODE_UNREGISTER = 3'd1,
    MODE_ADD_REF    = 3'd2,
    MODE_DROP_REF   = 3'd3,
    MODE_CHECK      = 3'd4,
    MODE_MARK       = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic                   ok;
    logic [IN_USE_BITS-1:0] in_use;
  } res_t;

endpackage

@@ hw/rtl/refcounted_handle_tracker.sv @@
// Top level of the reference-counted handle tracker: stream ports, enable
// register and result register. Depends on rht_pkg, rht_ctrl, rht_entry_mem.
//
//  channel  dir  group                      tdata                   tuser
//  in       in   in_tvalid/tready/tdata/user handle                  mode, handle_plausible
//  out      out  out_tvalid/tready/tdata/user entries_in_use (zero pad) ok
//  cfg      in   cfg_wr_en/cfg_wr_data      tracking_enabled        -
//
// When an item searches the table, it compares one entry per cycle through the
// single read port; an unregister that finds its handle then moves the last
// entry into the freed slot.
// Reset (synchronous, rst_n low) empties the table and disables tracking; no
// clearing pass is needed. in_tready is low while an item is at work; a full
// result register holds the finished item until out_tready.
`timescale 1ns / 1ps

module refcounted_handle_tracker
  import rht_pkg::*;
#(
  parameter int MAX_ENTRIES = 32,
  parameter int HANDLE_BITS = 48,
  parameter int REF_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,   // tracking_enabled
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((HANDLE_BITS+7)/8)*8-1:0]    in_tdata,      // handle
  input  logic [MODE_BITS:0]                  in_tuser,      // mode, handle_plausible
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_TDATA_W-1:0]              out_tdata,     // entries_in_use
  output logic                                out_tuser      // ok
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int DW = 1 + REF_BITS + HANDLE_BITS;

  logic          tracking_en_r;
  logic          out_valid_r;
  res_t          out_res_r;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [DW-1:0] mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [DW-1:0] mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracking_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      tracking_en_r <= cfg_wr_data;
    end
  end

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_res_r.in_use);
  assign out_tuser  = out_res_r.ok;

  rht_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .HANDLE_BITS (HANDLE_BITS),
    .REF_BITS    (REF_BITS),
    .AW          (AW),
    .CW          (CW),
    .DW          (DW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .tracking_en   (tracking_en_r),
    .cmd_valid     (in_tvalid),
    .cmd_ready     (in_tready),
    .cmd_mode      (mode_t'(in_tuser[MODE_BITS-1:0])),
    .cmd_handle    (in_tdata[HANDLE_BITS-1:0]),
    .cmd_plausible (in_tuser[MODE_BITS]),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data)
  );

  rht_entry_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

@@ hw/rtl/rht_entry_mem.sv @@
// Entry store of the handle tracker: one write port, one registered read port.
// Word holds {marked, refs, handle}. No package dependencies.
`timescale 1ns / 1ps

module rht_entry_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 65
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/rht_ctrl.sv @@
// Sequencer of the handle tracker: linear search with one shared comparator,
// saturating count update, and last-entry move on unregister.
// Depends on rht_pkg.
`timescale 1ns / 1ps

module rht_ctrl
  import rht_pkg::*;
#(
  parameter int MAX_ENTRIES = 32,
  parameter int HANDLE_BITS = 48,
  parameter int REF_BITS    = 16,
  parameter int AW          = 5,
  parameter int CW          = 6,
  parameter int DW          = 65
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   tracking_en,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  mode_t                  cmd_mode,
  input  logic [HANDLE_BITS-1:0] cmd_handle,
  input  logic                   cmd_plausible,
  output logic                   res_valid,
  input  logic                   res_ready,
  output res_t                   res,
  output logic                   mem_wr_en,
  output logic [AW-1:0]          mem_wr_addr,
  output logic [DW-1:0]          mem_wr_data,
  output logic                   mem_rd_en,
  output logic [AW-1:0]          mem_rd_addr,
  input  logic [DW-1:0]          mem_rd_data
);

  st_t                   state_r, state_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic                  hit_r, hit_nxt;
  logic [AW-1:0]         hit_idx_r, hit_idx_nxt;
  logic [DW-1:0]         hit_word_r, hit_word_nxt;
  logic                  ok_r, ok_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         scan_idx_r, scan_idx_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]         pend_idx_r, pend_idx_nxt;

  logic                  cmd_fire;
  logic                  lk_ok;
  logic                  need_search;
  logic                  imm_ok;
  logic                  scan_more;
  logic                  hit_now;
  logic                  scan_miss;
  logic [REF_BITS-1:0]   cur_refs;
  logic                  cur_mark;
  logic                  step_down;
  logic [REF_BITS-1:0]   refs_step;
  logic [REF_BITS-1:0]   refs_inc;
  logic [REF_BITS-1:0]   refs_dec;

  assign cmd_ready = (state_r == ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign lk_ok     = (cmd_handle != '0) && cmd_plausible;

  always_comb begin
    need_search = 1'b0;
    imm_ok      = 1'b0;
    case (cmd_mode)
      MODE_REGISTER, MODE_CHECK: begin
        if (lk_ok && !tracking_en) begin
          imm_ok = 1'b1;
        end else if (lk_ok) begin
          need_search = 1'b1;
        end
      end
      MODE_UNREGISTER: begin
        need_search = (cmd_handle != '0);
      end
      MODE_ADD_REF, MODE_DROP_REF: begin
        if (!tracking_en) begin
          imm_ok = 1'b1;
        end else begin
          need_search = lk_ok;
        end
      end
      MODE_MARK: begin
        need_search = lk_ok;
      end
      default: begin
        need_search = 1'b0;
      end
    endcase
  end

  assign scan_more = (scan_idx_r < count_r);
  assign hit_now   = (state_r == ST_SCAN) && rd_pend_r &&
                     (mem_rd_data[HANDLE_BITS-1:0] == handle_r);
  assign scan_miss = (state_r == ST_SCAN) && !rd_pend_r && !scan_more;

  // shared count unit
  assign cur_refs  = hit_word_r[HANDLE_BITS +: REF_BITS];
  assign cur_mark  = hit_word_r[DW-1];
  assign step_down = (mode_r == MODE_DROP_REF);
  assign refs_step = step_down ? (cur_refs - 1'b1) : (cur_refs + 1'b1);
  assign refs_inc  = (&cur_refs) ? cur_refs : refs_step;
  assign refs_dec  = (cur_refs == '0) ? cur_refs : refs_step;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_fire) begin
          state_nxt = need_search ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (hit_now || scan_miss) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = (mode_r == MODE_UNREGISTER && hit_r) ? ST_MOVE_RD : ST_DONE;
      end
      ST_MOVE_RD: begin
        state_nxt = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mode_nxt     = mode_r;
    handle_nxt   = handle_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_word_nxt = hit_word_r;
    ok_nxt       = ok_r;
    count_nxt    = count_r;
    scan_idx_nxt = scan_idx_r;
    rd_pend_nxt  = 1'b0;
    pend_idx_nxt = pend_idx_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = hit_idx_r;
    mem_wr_data  = hit_word_r;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = scan_idx_r[AW-1:0];
    res_valid    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_fire) begin
          mode_nxt     = cmd_mode;
          handle_nxt   = cmd_handle;
          hit_nxt      = 1'b0;
          ok_nxt       = imm_ok;
          scan_idx_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (hit_now) begin
          hit_nxt      = 1'b1;
          hit_idx_nxt  = pend_idx_r;
          hit_word_nxt = mem_rd_data;
        end
        mem_rd_en = scan_more && !hit_now;
        if (mem_rd_en) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          rd_pend_nxt  = 1'b1;
          pend_idx_nxt = scan_idx_r[AW-1:0];
        end
      end
      ST_UPDATE: begin
        ok_nxt = 1'b0;
        case (mode_r)
          MODE_REGISTER: begin
            if (hit_r) begin
              mem_wr_en   = 1'b1;
              mem_wr_data = {cur_mark, refs_inc, hit_word_r[HANDLE_BITS-1:0]};
              ok_nxt      = 1'b1;
            end else if (count_r != CW'(MAX_ENTRIES)) begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = count_r[AW-1:0];
              mem_wr_data = {1'b0, REF_BITS'(1), handle_r};
              count_nxt   = count_r + 1'b1;
              ok_nxt      = 1'b1;
            end
          end
          MODE_UNREGISTER: begin
            ok_nxt = hit_r;
          end
          MODE_ADD_REF: begin
            if (hit_r && !cur_mark) begin
              mem_wr_en   = 1'b1;
              mem_wr_data = {cur_mark, refs_inc, hit_word_r[HANDLE_BITS-1:0]};
              ok_nxt      = 1'b1;
            end
          end
          MODE_DROP_REF: begin
            if (hit_r) begin
              mem_wr_en   = 1'b1;
              mem_wr_data = {cur_mark, refs_dec, hit_word_r[HANDLE_BITS-1:0]};
              ok_nxt      = 1'b1;
            end
          end
          MODE_CHECK: begin
            ok_nxt = hit_r && !cur_mark && (cur_refs != '0);
          end
          MODE_MARK: begin
            if (hit_r) begin
              mem_wr_en   = 1'b1;
              mem_wr_data = {1'b1, hit_word_r[DW-2:0]};
              ok_nxt      = 1'b1;
            end
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end
      ST_MOVE_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = AW'(count_r - 1'b1);
      end
      ST_MOVE_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = mem_rd_data;
        count_nxt   = count_r - 1'b1;
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign res.ok     = ok_r;
  assign res.in_use = IN_USE_BITS'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    handle_r   <= handle_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_word_r <= hit_word_nxt;
    ok_r       <= ok_nxt;
    scan_idx_r <= scan_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_UPDATE && state_r != ST_MOVE_WR) |=> $stable(count_r))
    else $error("entry count changed outside update");

  a_move_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOVE_WR) |=> (count_r == $past(count_r) - 1'b1))
    else $error("unregister did not drop the count");

  a_move_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOVE_RD) |-> (hit_r && mode_r == MODE_UNREGISTER && count_r != '0))
    else $error("entry move without a matched unregister");

endmodule
